/* hw/rtl/mbsa_pkg.sv */
package mbsa_pkg;

    localparam int SYSEX_DEPTH = 64;
    localparam int ADDR_W      = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
    localparam int CNT_W       = $clog2(SYSEX_DEPTH + 1);

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] SYSTEM_MIN   = 8'hF0;

    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;

    localparam logic [1:0] LEN_SHORT    = 2'd2;
    localparam logic [1:0] LEN_LONG     = 2'd3;

    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_SYSEX   = 1'b1;

    function automatic logic [1:0] msg_length(input logic [7:0] status);
        logic [1:0] len;
        len = LEN_LONG;
        if (status[7:4] == HI_PROGRAM || status[7:4] == HI_PRESSURE) begin
            len = LEN_SHORT;
        end
        return len;
    endfunction

endpackage

/* hw/rtl/midi_byte_stream_assembler.sv */
// MIDI byte stream assembler: takes one received byte per word and returns assembled channel
// messages (running status, two or three bytes) or, for a complete SysEx, every buffered byte
// from F0 to F7 with the last one flagged. Realtime bytes are dropped. A complete SysEx of N
// bytes is read back from the SysEx store (one write port, one read port), whose read data is
// registered, at one byte per cycle when the sink is ready; input is held off from the F7 until
// the last byte is loaded into the output register.
module midi_byte_stream_assembler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_status,
    output logic [6:0] o_data_first,
    output logic [6:0] o_data_second,
    output logic [1:0] o_message_length,
    output logic [7:0] o_sysex_byte,
    output logic       o_last
);

    typedef enum logic {ST_IDLE, ST_REPLAY} t_state;

    t_state r_state, n_state;

    logic       r_out_valid, n_out_valid;
    logic       r_kind, n_kind;
    logic [7:0] r_status, n_status;
    logic [6:0] r_data_first, n_data_first;
    logic [6:0] r_data_second, n_data_second;
    logic [1:0] r_message_length, n_message_length;
    logic [7:0] r_sysex_byte, n_sysex_byte;
    logic       r_last, n_last;

    logic [7:0] r_running_status, n_running_status;
    logic [1:0] r_expected_length, n_expected_length;
    logic [1:0] r_collected_count, n_collected_count;
    logic [6:0] r_held_data, n_held_data;
    logic       r_in_sysex, n_in_sysex;
    logic       r_sx_overflow, n_sx_overflow;
    logic [mbsa_pkg::CNT_W-1:0]  r_sx_count, n_sx_count;
    logic [mbsa_pkg::ADDR_W-1:0] r_rd_idx, n_rd_idx;

    logic [7:0] mem [mbsa_pkg::SYSEX_DEPTH];
    logic [7:0] r_mem_q;
    logic       mem_we;
    logic       mem_re;
    logic [mbsa_pkg::ADDR_W-1:0] mem_wa;
    logic [mbsa_pkg::ADDR_W-1:0] mem_ra;
    logic [7:0] mem_wd;

    logic out_free;
    logic in_acc;
    logic rep_last;
    logic sx_has_room;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign rep_last    = (mbsa_pkg::CNT_W'(r_rd_idx) + mbsa_pkg::CNT_W'(1)) == r_sx_count;
    assign sx_has_room = r_sx_count < mbsa_pkg::CNT_W'(mbsa_pkg::SYSEX_DEPTH);

    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid && !i_out_ready;
        n_kind            = r_kind;
        n_status          = r_status;
        n_data_first      = r_data_first;
        n_data_second     = r_data_second;
        n_message_length  = r_message_length;
        n_sysex_byte      = r_sysex_byte;
        n_last            = r_last;
        n_running_status  = r_running_status;
        n_expected_length = r_expected_length;
        n_collected_count = r_collected_count;
        n_held_data       = r_held_data;
        n_in_sysex        = r_in_sysex;
        n_sx_overflow     = r_sx_overflow;
        n_sx_count        = r_sx_count;
        n_rd_idx          = r_rd_idx;
        mem_we            = 1'b0;
        mem_wa            = r_sx_count[mbsa_pkg::ADDR_W-1:0];
        mem_wd            = i_byte_in;
        mem_re            = 1'b0;
        mem_ra            = r_rd_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_byte_in < mbsa_pkg::REALTIME_MIN) begin
                    if (r_in_sysex && !(i_byte_in[7] && i_byte_in != mbsa_pkg::SYSEX_END)) begin
                        if (sx_has_room) begin
                            mem_we     = 1'b1;
                            n_sx_count = r_sx_count + mbsa_pkg::CNT_W'(1);
                        end else begin
                            n_sx_overflow = 1'b1;
                        end
                        if (i_byte_in == mbsa_pkg::SYSEX_END) begin
                            n_in_sysex    = 1'b0;
                            n_sx_overflow = 1'b0;
                            if (!r_sx_overflow && sx_has_room) begin
                                n_state  = ST_REPLAY;
                                mem_re   = 1'b1;
                                mem_ra   = '0;
                                n_rd_idx = '0;
                            end else begin
                                n_sx_count = '0;
                            end
                        end
                    end else if (i_byte_in[7]) begin
                        n_in_sysex    = 1'b0;
                        n_sx_overflow = 1'b0;
                        n_sx_count    = '0;
                        if (i_byte_in == mbsa_pkg::SYSEX_START) begin
                            n_in_sysex        = 1'b1;
                            mem_we            = 1'b1;
                            mem_wa            = '0;
                            n_sx_count        = mbsa_pkg::CNT_W'(1);
                            n_running_status  = '0;
                            n_expected_length = '0;
                            n_collected_count = '0;
                        end else if (i_byte_in >= mbsa_pkg::SYSTEM_MIN) begin
                            n_running_status  = '0;
                            n_expected_length = '0;
                            n_collected_count = '0;
                        end else begin
                            n_running_status  = i_byte_in;
                            n_expected_length = mbsa_pkg::msg_length(i_byte_in);
                            n_collected_count = 2'd1;
                        end
                    end else if (r_running_status != '0 && r_expected_length >= 2'd2) begin
                        if (r_collected_count + 2'd1 < r_expected_length) begin
                            n_held_data       = i_byte_in[6:0];
                            n_collected_count = r_collected_count + 2'd1;
                        end else begin
                            n_out_valid      = 1'b1;
                            n_kind           = mbsa_pkg::KIND_CHANNEL;
                            n_status         = r_running_status;
                            n_message_length = r_expected_length;
                            n_sysex_byte     = '0;
                            n_last           = 1'b1;
                            if (r_expected_length == mbsa_pkg::LEN_SHORT) begin
                                n_data_first  = i_byte_in[6:0];
                                n_data_second = '0;
                            end else begin
                                n_data_first  = r_held_data;
                                n_data_second = i_byte_in[6:0];
                            end
                            n_collected_count = 2'd1;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_kind           = mbsa_pkg::KIND_SYSEX;
                    n_status         = '0;
                    n_data_first     = '0;
                    n_data_second    = '0;
                    n_message_length = '0;
                    n_sysex_byte     = r_mem_q;
                    n_last           = rep_last;
                    if (rep_last) begin
                        n_state    = ST_IDLE;
                        n_sx_count = '0;
                    end else begin
                        mem_re   = 1'b1;
                        mem_ra   = r_rd_idx + mbsa_pkg::ADDR_W'(1);
                        n_rd_idx = r_rd_idx + mbsa_pkg::ADDR_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_out_valid       <= 1'b0;
            r_running_status  <= '0;
            r_expected_length <= '0;
            r_collected_count <= '0;
            r_held_data       <= '0;
            r_in_sysex        <= 1'b0;
            r_sx_overflow     <= 1'b0;
            r_sx_count        <= '0;
            r_rd_idx          <= '0;
        end else begin
            r_state           <= n_state;
            r_out_valid       <= n_out_valid;
            r_running_status  <= n_running_status;
            r_expected_length <= n_expected_length;
            r_collected_count <= n_collected_count;
            r_held_data       <= n_held_data;
            r_in_sysex        <= n_in_sysex;
            r_sx_overflow     <= n_sx_overflow;
            r_sx_count        <= n_sx_count;
            r_rd_idx          <= n_rd_idx;
        end
        r_kind           <= n_kind;
        r_status         <= n_status;
        r_data_first     <= n_data_first;
        r_data_second    <= n_data_second;
        r_message_length <= n_message_length;
        r_sysex_byte     <= n_sysex_byte;
        r_last           <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_status         = r_status;
    assign o_data_first     = r_data_first;
    assign o_data_second    = r_data_second;
    assign o_message_length = r_message_length;
    assign o_sysex_byte     = r_sysex_byte;
    assign o_last           = r_last;

    a_replay_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLAY) |-> !o_in_ready)
        else $error("input taken during replay");

    a_replay_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLAY) |-> (mbsa_pkg::CNT_W'(r_rd_idx) < r_sx_count))
        else $error("replay index past stored count");

    a_running_status_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running_status != '0) |->
            ((r_expected_length == mbsa_pkg::LEN_SHORT ||
              r_expected_length == mbsa_pkg::LEN_LONG) && !r_in_sysex))
        else $error("running status inconsistent");

    a_sysex_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_sysex |-> (r_sx_count != '0))
        else $error("sysex open with empty store");

    a_channel_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == mbsa_pkg::KIND_CHANNEL) |-> r_last)
        else $error("channel message without last");

endmodule
